// File: rtl/bnss_pkg.sv
// shared types and constants of the bus node status supervisor
package bnss_pkg;

  localparam int NODE_W  = 4;
  localparam int LIMIT_W = 5;

  localparam logic [7:0] ST_ACTIVE   = 8'h01;
  localparam logic [7:0] ST_TIMEOUT  = 8'h02;
  localparam logic [7:0] ST_MODEFAIL = 8'h04;
  localparam logic [7:0] ST_SENDFAIL = 8'h08;
  localparam logic [7:0] ST_WAITING  = 8'h10;
  localparam logic [7:0] ST_FAULT    = 8'h80;
  localparam logic [7:0] REPLY_KEEP  = 8'hed;
  localparam logic [7:0] NO_NODE     = 8'hff;

  localparam logic [7:0] CAUSE_SILENT = 8'h01;
  localparam logic [7:0] CAUSE_FAULT  = 8'h80;

  localparam logic [3:0] MAX_NODES_RST = 4'd3;

  typedef enum logic [1:0] {
    KIND_POLL  = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_OUT   = 2'd2,
    KIND_MODE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_COUNT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic update;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/bnss_ctrl.sv
// sequencer of the status supervisor
module bnss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bnss_pkg::dp_sts_t sts,
  output bnss_pkg::dp_cmd_t cmd
);
  import bnss_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.update   = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_COUNT;
      end
      S_COUNT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/bnss_dp.sv
// status table, error registers, active count and result register
module bnss_dp #(
  parameter int NODE_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bnss_pkg::dp_cmd_t cmd,
  output bnss_pkg::dp_sts_t sts,
  input  logic [1:0]        in_kind,
  input  logic [3:0]        in_node,
  input  logic              in_received,
  input  logic              in_node_fault,
  input  logic              in_sent,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_node_status,
  output logic [3:0]        out_active_count,
  output logic [7:0]        out_last_error_node,
  output logic [7:0]        out_first_error_node,
  output logic [7:0]        out_error_cause,
  output logic              out_rejected
);
  import bnss_pkg::*;

  localparam int IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CNT_W = $clog2(NODE_SLOTS + 1);
  localparam logic [LIMIT_W-1:0] SLOTS_L = LIMIT_W'(NODE_SLOTS);

  logic [7:0]        status_r [NODE_SLOTS];
  logic [3:0]        max_nodes_r;
  logic [7:0]        recent_r, first_r, cause_r;
  kind_t             kind_r;
  logic [3:0]        node_r;
  logic              received_r, fault_r, sent_r;
  logic [7:0]        st_r;
  logic              rej_r;
  logic              out_valid_r;
  logic [7:0]        out_status_r, out_recent_r, out_first_r, out_cause_r;
  logic [3:0]        out_count_r;
  logic              out_rej_r;

  logic [LIMIT_W-1:0] lim;
  logic               rej;
  logic [3:0]         node_m1;
  logic [IDX_W-1:0]   ix;
  logic [7:0]         st_old, st_new;
  logic               err, err_first;
  logic [7:0]         err_cause;
  logic [CNT_W-1:0]   cnt;

  assign lim     = ({1'b0, max_nodes_r} > SLOTS_L) ? SLOTS_L : {1'b0, max_nodes_r};
  assign rej     = (node_r == 4'd0) || ({1'b0, node_r} > lim);
  assign node_m1 = node_r - 4'd1;
  assign ix      = node_m1[IDX_W-1:0];
  assign st_old  = status_r[ix];

  always_comb begin
    st_new    = st_old;
    err       = 1'b0;
    err_cause = CAUSE_SILENT;
    unique case (kind_r)
      KIND_POLL: begin
        st_new = st_old | ST_WAITING;
      end
      KIND_REPLY: begin
        if (received_r) begin
          st_new = (((st_old & ~ST_FAULT) | (fault_r ? ST_FAULT : 8'h00)) & REPLY_KEEP)
                   | ST_ACTIVE;
          err       = fault_r;
          err_cause = CAUSE_FAULT;
        end else if ((st_old & ST_TIMEOUT) != 8'h00) begin
          if ((st_old & ST_ACTIVE) != 8'h00) begin
            st_new = st_old & ~ST_ACTIVE;
            err    = 1'b1;
          end
        end else begin
          st_new = st_old | ST_TIMEOUT;
        end
      end
      KIND_OUT: begin
        st_new = sent_r ? (st_old & ~ST_SENDFAIL) : (st_old | ST_SENDFAIL);
      end
      KIND_MODE: begin
        st_new = sent_r ? (st_old & ~ST_MODEFAIL) : (st_old | ST_MODEFAIL);
      end
      default: begin
        st_new = st_old;
      end
    endcase
  end

  assign err_first = err && (first_r == NO_NODE);

  always_comb begin
    cnt = '0;
    for (int i = 0; i < NODE_SLOTS; i++) begin
      if ((LIMIT_W'(i) < lim) && status_r[i][0]) begin
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r     <= kind_t'(in_kind);
      node_r     <= in_node;
      received_r <= in_received;
      fault_r    <= in_node_fault;
      sent_r     <= in_sent;
    end
  end

  // node state and error registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODE_SLOTS; i++) begin
        status_r[i] <= 8'h00;
      end
      recent_r    <= NO_NODE;
      first_r     <= NO_NODE;
      cause_r     <= 8'h00;
      max_nodes_r <= MAX_NODES_RST;
    end else begin
      if (cfg_wr_en) begin
        max_nodes_r <= cfg_wr_data;
      end
      if (cmd.update && !rej) begin
        status_r[ix] <= st_new;
        if (err) begin
          recent_r <= {4'h0, node_r};
        end
        if (err_first) begin
          first_r <= {4'h0, node_r};
          cause_r <= cause_r | err_cause;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      st_r  <= rej ? 8'h00 : st_new;
      rej_r <= rej;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= st_r;
      out_count_r  <= 4'(cnt);
      out_recent_r <= recent_r;
      out_first_r  <= first_r;
      out_cause_r  <= cause_r;
      out_rej_r    <= rej_r;
    end
  end

  assign sts.out_free         = !out_valid_r || out_ready;
  assign out_valid            = out_valid_r;
  assign out_node_status      = out_status_r;
  assign out_active_count     = out_count_r;
  assign out_last_error_node  = out_recent_r;
  assign out_first_error_node = out_first_r;
  assign out_error_cause      = out_cause_r;
  assign out_rejected         = out_rej_r;

endmodule

// File: rtl/bus_node_status_supervisor_core.sv
// top level of the bus node status supervisor
// Each event item updates its node's status byte and the error registers and
// yields one result item. An item is captured when it is accepted in S_IDLE,
// the table is updated in S_UPDATE and the result, with the active count, is
// loaded in S_COUNT once the result register is free, as set by the sequencer
// in bnss_ctrl; out_valid is registered. A new item is taken the cycle after
// the result is loaded, so no new item is taken while one is in work.
// max_nodes is written through cfg_wr_en and cfg_wr_data and resets to 3.
module bus_node_status_supervisor_core #(
  parameter int NODE_SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [3:0] in_node,
  input  logic       in_received,
  input  logic       in_node_fault,
  input  logic       in_sent,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_node_status,
  output logic [3:0] out_active_count,
  output logic [7:0] out_last_error_node,
  output logic [7:0] out_first_error_node,
  output logic [7:0] out_error_cause,
  output logic       out_rejected,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);
  import bnss_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bnss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bnss_dp #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_kind              (in_kind),
    .in_node              (in_node),
    .in_received          (in_received),
    .in_node_fault        (in_node_fault),
    .in_sent              (in_sent),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_node_status      (out_node_status),
    .out_active_count     (out_active_count),
    .out_last_error_node  (out_last_error_node),
    .out_first_error_node (out_first_error_node),
    .out_error_cause      (out_error_cause),
    .out_rejected         (out_rejected)
  );

endmodule

// File: rtl/bnss_checker.sv
// port checker of the status supervisor and its bind
module bnss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_node_status,
  input logic [7:0] out_first_error_node,
  input logic [7:0] out_error_cause,
  input logic       out_rejected
);
  import bnss_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_status))
    else $error("result changed while stalled");

  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_node_status == 8'h00)
    else $error("rejected item with nonzero status");

  a_cause_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_error_node == NO_NODE |-> out_error_cause == 8'h00)
    else $error("error cause without first error node");

  a_unused_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_node_status[6:5] == 2'b00)
    else $error("unused status bits set");

  // one item at a time: no new item while the previous one is in work
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another in work");

endmodule

bind bus_node_status_supervisor_core bnss_checker u_bnss_checker (.*);

// File: verif/tb_top.sv
// testbench for the bus node status supervisor: random and directed node events, checked
`timescale 1ns / 100ps

module tb_top;
  import bnss_pkg::*;

  localparam int NODE_SLOTS = 8;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    kind_t      kind;
    logic [3:0] node;
    logic       received;
    logic       node_fault;
    logic       sent;
  } bus_event_t;

  typedef struct {
    logic [7:0] node_status;
    logic [3:0] active_count;
    logic [7:0] last_error_node;
    logic [7:0] first_error_node;
    logic [7:0] error_cause;
    logic       rejected;
  } status_report_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_kind = '0;
  logic [3:0] in_node = '0;
  logic       in_received = 1'b0;
  logic       in_node_fault = 1'b0;
  logic       in_sent = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_node_status;
  logic [3:0] out_active_count;
  logic [7:0] out_last_error_node;
  logic [7:0] out_first_error_node;
  logic [7:0] out_error_cause;
  logic       out_rejected;
  logic       cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = '0;

  // predictor state
  logic [7:0] status_tab [NODE_SLOTS];
  logic [7:0] last_err = NO_NODE;
  logic [7:0] first_err = NO_NODE;
  logic [7:0] cause_reg = '0;
  logic [3:0] node_cap = MAX_NODES_RST;

  bus_event_t     event_backlog [$];
  status_report_t reports_due [$];
  bus_event_t     cur_ev;

  logic offering = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   send_calm = 0;
  int   recv_calm = 0;
  int   hold_left = 0;
  logic squeezed = 1'b0;
  int   accepted_n = 0;
  int   errors = 0;
  int   cycles = 0;

  bus_node_status_supervisor_core #(
    .NODE_SLOTS(NODE_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_node(in_node),
    .in_received(in_received),
    .in_node_fault(in_node_fault),
    .in_sent(in_sent),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_node_status(out_node_status),
    .out_active_count(out_active_count),
    .out_last_error_node(out_last_error_node),
    .out_first_error_node(out_first_error_node),
    .out_error_cause(out_error_cause),
    .out_rejected(out_rejected),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NODE_SLOTS; i++) status_tab[i] = '0;
  end

  function automatic int node_span();
    return (node_cap > NODE_SLOTS) ? NODE_SLOTS : int'(node_cap);
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 40) $display("error: %s got 0x%0h, want 0x%0h", what, got, want);
    errors++;
  endtask

  task automatic log_error(input logic [3:0] n, input logic [7:0] cause);
    last_err = {4'd0, n};
    if (first_err == NO_NODE) begin
      first_err = {4'd0, n};
      cause_reg = cause_reg | cause;
    end
  endtask

  // works out the report for one event and updates the status table
  task automatic apply_event(input bus_event_t ev, output status_report_t rep);
    int span;
    int idx;
    int count;
    logic [7:0] st;
    logic bad;
    span = node_span();
    bad = (ev.node == 0) || (int'(ev.node) > span);
    st = '0;
    count = 0;
    if (!bad) begin
      idx = int'(ev.node) - 1;
      st = status_tab[idx];
      case (ev.kind)
        KIND_POLL: begin
          st = st | ST_WAITING;
        end
        KIND_REPLY: begin
          if (ev.received) begin
            st = ((st & ~ST_FAULT) | (ev.node_fault ? ST_FAULT : 8'h00)) & REPLY_KEEP;
            st = st | ST_ACTIVE;
            if ((st & ST_FAULT) != 0) log_error(ev.node, CAUSE_FAULT);
          end else if ((st & ST_TIMEOUT) != 0) begin
            if ((st & ST_ACTIVE) != 0) begin
              st = st & ~ST_ACTIVE;
              log_error(ev.node, CAUSE_SILENT);
            end
          end else begin
            st = st | ST_TIMEOUT;
          end
        end
        KIND_OUT: begin
          st = ev.sent ? (st & ~ST_SENDFAIL) : (st | ST_SENDFAIL);
        end
        default: begin
          st = ev.sent ? (st & ~ST_MODEFAIL) : (st | ST_MODEFAIL);
        end
      endcase
      status_tab[idx] = st;
    end
    for (int i = 0; i < span; i++) if ((status_tab[i] & ST_ACTIVE) != 0) count++;
    rep.node_status = bad ? 8'h00 : st;
    rep.active_count = count[3:0];
    rep.last_error_node = last_err;
    rep.first_error_node = first_err;
    rep.error_cause = cause_reg;
    rep.rejected = bad;
  endtask

  // sender
  always @(posedge clk) begin : drive_proc
    status_report_t rep;
    if (!rst_n) begin
      offering = 1'b0;
      gap_left = 0;
      cur_ev = '{KIND_POLL, 4'd0, 1'b0, 1'b0, 1'b0};
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_event(cur_ev, rep);
        reports_due.push_back(rep);
        accepted_n <= accepted_n + 1;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (event_backlog.size() > 0) begin
          cur_ev = event_backlog.pop_front();
          offering = 1'b1;
          gap_left = draw_wait(send_calm);
        end
      end
      in_valid <= offering;
      in_kind <= cur_ev.kind;
      in_node <= cur_ev.node;
      in_received <= cur_ev.received;
      in_node_fault <= cur_ev.node_fault;
      in_sent <= cur_ev.sent;
    end
  end

  // long receiver hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      squeezed <= 1'b0;
    end else if (!squeezed && accepted_n >= 100) begin
      hold_left <= 250;
      squeezed <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin : check_proc
    status_report_t want;
    if (!rst_n) begin
      stall_left = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          report_mismatch("unexpected item, status", out_node_status, 0);
        end else begin
          want = reports_due.pop_front();
          if (out_node_status !== want.node_status)
            report_mismatch("node_status", out_node_status, want.node_status);
          if (out_active_count !== want.active_count)
            report_mismatch("active_count", out_active_count, want.active_count);
          if (out_last_error_node !== want.last_error_node)
            report_mismatch("last_error_node", out_last_error_node, want.last_error_node);
          if (out_first_error_node !== want.first_error_node)
            report_mismatch("first_error_node", out_first_error_node, want.first_error_node);
          if (out_error_cause !== want.error_cause)
            report_mismatch("error_cause", out_error_cause, want.error_cause);
          if (out_rejected !== want.rejected)
            report_mismatch("rejected", out_rejected, want.rejected);
        end
        stall_left = draw_wait(recv_calm);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_event(input kind_t k, input logic [3:0] n, input logic r,
                             input logic f, input logic s);
    event_backlog.push_back('{k, n, r, f, s});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (event_backlog.size() != 0 || in_valid || reports_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_max_nodes(input logic [3:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    node_cap = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // mostly poll / reply / send sequences for one node, some noise items
  task automatic random_phase(input int goal);
    int counted;
    int span;
    logic [3:0] n;
    logic r;
    counted = 0;
    span = node_span();
    while (counted < goal) begin
      if (span > 0 && $urandom_range(0, 3) != 0) begin
        n = 4'($urandom_range(1, span));
        queue_event(KIND_POLL, n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        r = ($urandom_range(0, 2) != 0);
        queue_event(KIND_REPLY, n, r, ($urandom_range(0, 3) == 0),
                    1'($urandom_range(0, 1)));
        counted += 2;
        if (!r && $urandom_range(0, 1) == 1) begin
          queue_event(KIND_REPLY, n, 1'b0, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          counted++;
        end
        if ($urandom_range(0, 1) == 1) begin
          queue_event(KIND_OUT, n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 4) != 0));
          counted++;
        end
        if ($urandom_range(0, 2) == 0) begin
          queue_event(KIND_MODE, n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 4) != 0));
          counted++;
        end
      end else begin
        n = 4'($urandom_range(0, 15));
        queue_event(kind_t'($urandom_range(0, 3)), n, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (span == 0 || (n != 0 && int'(n) <= span)) counted++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset setting of three nodes
    queue_event(KIND_POLL, 4'd1, 1'b0, 1'b0, 1'b0);
    queue_event(KIND_REPLY, 4'd1, 1'b1, 1'b0, 1'b0);
    queue_event(KIND_OUT, 4'd1, 1'b0, 1'b0, 1'b0);
    queue_event(KIND_OUT, 4'd1, 1'b0, 1'b0, 1'b1);
    queue_event(KIND_MODE, 4'd1, 1'b0, 1'b0, 1'b0);
    queue_event(KIND_MODE, 4'd1, 1'b0, 1'b0, 1'b1);
    queue_event(KIND_REPLY, 4'd2, 1'b0, 1'b0, 1'b0);
    queue_event(KIND_REPLY, 4'd2, 1'b0, 1'b0, 1'b0);
    queue_event(KIND_REPLY, 4'd2, 1'b1, 1'b0, 1'b0);
    queue_event(KIND_REPLY, 4'd2, 1'b0, 1'b0, 1'b0);
    queue_event(KIND_REPLY, 4'd2, 1'b0, 1'b0, 1'b0);
    queue_event(KIND_REPLY, 4'd3, 1'b1, 1'b1, 1'b0);
    queue_event(KIND_REPLY, 4'd3, 1'b1, 1'b0, 1'b0);
    queue_event(KIND_POLL, 4'd0, 1'b0, 1'b0, 1'b0);
    queue_event(KIND_REPLY, 4'd4, 1'b1, 1'b1, 1'b0);
    queue_event(KIND_MODE, 4'd15, 1'b1, 1'b1, 1'b0);
    queue_event(KIND_POLL, 4'd3, 1'b1, 1'b1, 1'b1);
    queue_event(KIND_OUT, 4'd3, 1'b1, 1'b1, 1'b1);
    queue_event(KIND_REPLY, 4'd1, 1'b0, 1'b1, 1'b1);
    queue_event(KIND_REPLY, 4'd1, 1'b0, 1'b0, 1'b1);

    wait_idle();
    write_max_nodes(4'd8);
    random_phase(150);
    wait_idle();
    write_max_nodes(4'd1);
    random_phase(60);
    wait_idle();
    write_max_nodes(4'd0);
    random_phase(12);
    wait_idle();
    write_max_nodes(4'd15);
    random_phase(150);
    wait_idle();
    write_max_nodes(4'd5);
    random_phase(100);
    wait_idle();
    write_max_nodes(4'd2);
    random_phase(40);

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
